@@ rtl/smab_pkg.sv @@
`timescale 1ns / 1ps

package smab_pkg;

  // Most results that one input word can cause
  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntWidth   = $clog2(MaxResults + 1);

  // Host command bytes
  localparam logic [7:0] CmdPing    = 8'h01;
  localparam logic [7:0] CmdLoad    = 8'h03;
  localparam logic [7:0] CmdCall    = 8'h05;
  localparam logic [7:0] CmdJump    = 8'h06;
  localparam logic [7:0] CmdReadInc = 8'h08;
  localparam logic [7:0] CmdWrite   = 8'h0A;
  localparam logic [7:0] CmdReadFix = 8'h0C;

  // Answer bytes sent back to the host
  localparam logic [7:0] AnsPing  = 8'h02;
  localparam logic [7:0] AnsLoad  = 8'h04;
  localparam logic [7:0] AnsStart = 8'h07;
  localparam logic [7:0] AnsRead  = 8'h09;
  localparam logic [7:0] AnsWrite = 8'h0B;

  // Type byte codes
  localparam logic [7:0] TypeByte = 8'h01;
  localparam logic [7:0] TypeWord = 8'h02;
  localparam logic [7:0] TypeLong = 8'h04;

  typedef enum logic [1:0] {
    KIND_TX    = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_START = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_WORD = 2'd1,
    SIZE_LONG = 2'd2,
    SIZE_NONE = 2'd3
  } size_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_COUNT = 3'd2,
    PH_ADDR  = 3'd3,
    PH_DATA  = 3'd4,
    PH_WAIT  = 3'd5
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic [31:0] bus_address;
    logic [31:0] write_value;
    size_e       size;
    logic        call_mode;
    logic        last;
  } result_t;

  typedef result_t result_list_t [MaxResults];

  function automatic size_e size_code(logic [7:0] t);
    size_e s;
    case (t)
      TypeByte: s = SIZE_BYTE;
      TypeWord: s = SIZE_WORD;
      TypeLong: s = SIZE_LONG;
      default:  s = SIZE_NONE;
    endcase
    return s;
  endfunction

  // Bytes moved per item of a size; an unknown size never moves data
  function automatic logic [2:0] size_bytes(size_e s);
    logic [2:0] nb;
    case (s)
      SIZE_BYTE: nb = 3'd1;
      SIZE_WORD: nb = 3'd2;
      default:   nb = 3'd4;
    endcase
    return nb;
  endfunction

  function automatic result_t mk_result(kind_e k, logic [7:0] tx, logic [31:0] addr,
                                        logic [31:0] val, size_e s, logic call);
    result_t r;
    r.kind        = k;
    r.tx_byte     = tx;
    r.bus_address = addr;
    r.write_value = val;
    r.size        = s;
    r.call_mode   = call;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/serial_memory_access_bridge_unit.sv @@
`timescale 1ns / 1ps

// Serial host-to-bus bridge.
// Input channel (in_valid_i / in_stall_o): each word is either a host byte
// (operation_i = 0, rx_byte_i) or memory read data (operation_i = 1,
// read_data_i, right aligned). Host bytes form commands: ping, load, call,
// jump, incrementing read, fixed read and write, with big-endian fields.
// Output channel (out_valid_o / out_stall_i): one result word per handshake:
// a byte to transmit, a memory write, a read request or a program start;
// last_o marks the final word caused by one input word.
// The results of a word appear from the cycle after it is accepted, one per
// cycle while the receiver takes them. Input: one word per cycle while the
// receiver does not stall and each word causes at most one result; a word
// with more results (up to 5 for a long read response plus the next request)
// keeps the input stalled until they leave, and the next word is taken in the
// cycle the last of them leaves.
// Reset clears the parser to idle and empties the result queue.
// While the receiver stalls, the head word holds and input stalls as soon
// as the queue cannot take another word's results.

module serial_memory_access_bridge_unit #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [31:0] bus_address_o,
  output logic [31:0] write_value_o,
  output logic [1:0]  access_size_o,
  output logic        call_mode_o,
  output logic        last_o
);

  logic                          accept;
  logic                          take;
  logic                          space;
  smab_pkg::result_list_t        res;
  logic [smab_pkg::CntWidth-1:0] res_cnt;
  smab_pkg::result_t             head;

  assign in_stall_o = !space;
  assign accept     = in_valid_i && space;
  assign take       = out_valid_o && !out_stall_i;

  smab_parser #(
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .operation_i (operation_i),
    .rx_byte_i   (rx_byte_i),
    .read_data_i (read_data_i),
    .res_o       (res),
    .res_cnt_o   (res_cnt)
  );

  smab_result_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (accept),
    .res_i     (res),
    .res_cnt_i (res_cnt),
    .take_i    (take),
    .space_o   (space),
    .valid_o   (out_valid_o),
    .head_o    (head)
  );

  assign kind_o        = head.kind;
  assign tx_byte_o     = head.tx_byte;
  assign bus_address_o = head.bus_address;
  assign write_value_o = head.write_value;
  assign access_size_o = head.size;
  assign call_mode_o   = head.call_mode;
  assign last_o        = head.last;

  // A new word enters only as the final pending result leaves
  a_accept_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || (last_o && !out_stall_i)))
    else $error("input accepted while results still pending");

  // A start always ends its command
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == smab_pkg::KIND_START) |-> last_o)
    else $error("start result not marked last");

  // Only transmit words carry a byte
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != smab_pkg::KIND_TX) |-> (tx_byte_o == 8'd0))
    else $error("non-transmit result carries a byte");

endmodule

@@ rtl/smab_parser.sv @@
`timescale 1ns / 1ps

module smab_parser #(
  parameter int unsigned ADDRESS_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          operation_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [31:0]                   read_data_i,
  output smab_pkg::result_list_t        res_o,
  output logic [smab_pkg::CntWidth-1:0] res_cnt_o
);

  localparam int unsigned CntW = smab_pkg::CntWidth;

  smab_pkg::phase_e         phase_q, phase_d;
  logic [7:0]               cmd_q, cmd_d;
  smab_pkg::size_e          size_q, size_d;
  logic [31:0]              items_q, items_d;
  logic [ADDRESS_WIDTH-1:0] addr_q, addr_d;
  logic [31:0]              word_q, word_d;
  logic [2:0]               bcnt_q, bcnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= smab_pkg::PH_IDLE;
      cmd_q   <= 8'd0;
      size_q  <= smab_pkg::SIZE_BYTE;
      items_q <= 32'd0;
      addr_q  <= '0;
      word_q  <= 32'd0;
      bcnt_q  <= 3'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      size_q  <= size_d;
      items_q <= items_d;
      addr_q  <= addr_d;
      word_q  <= word_d;
      bcnt_q  <= bcnt_d;
    end
  end

  always_comb begin
    logic [31:0]              word_sh;
    logic [2:0]               bcnt_inc;
    logic [ADDRESS_WIDTH-1:0] addr_new;
    logic [ADDRESS_WIDTH-1:0] addr_next;
    smab_pkg::size_e          dsize;
    logic [2:0]               nb;
    logic [CntW-1:0]          n;

    phase_d  = phase_q;
    cmd_d    = cmd_q;
    size_d   = size_q;
    items_d  = items_q;
    addr_d   = addr_q;
    word_d   = word_q;
    bcnt_d   = bcnt_q;
    n        = '0;
    for (int i = 0; i < smab_pkg::MaxResults; i++) begin
      res_o[i] = '0;
    end

    word_sh   = {word_q[23:0], rx_byte_i};
    bcnt_inc  = bcnt_q + 3'd1;
    addr_new  = word_sh[ADDRESS_WIDTH-1:0];
    dsize     = (cmd_q == smab_pkg::CmdLoad) ? smab_pkg::SIZE_BYTE : size_q;
    nb        = smab_pkg::size_bytes(operation_i ? size_q : dsize);
    addr_next = addr_q + ADDRESS_WIDTH'(nb);

    if (!operation_i) begin
      case (phase_q)
        smab_pkg::PH_IDLE: begin
          word_d = 32'd0;
          bcnt_d = 3'd0;
          if (rx_byte_i == smab_pkg::CmdPing) begin
            res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, smab_pkg::AnsPing, 32'd0,
                                           32'd0, smab_pkg::SIZE_BYTE, 1'b0);
            n = n + CntW'(1);
          end else if (rx_byte_i == smab_pkg::CmdLoad) begin
            cmd_d   = rx_byte_i;
            phase_d = smab_pkg::PH_COUNT;
          end else if (rx_byte_i == smab_pkg::CmdCall || rx_byte_i == smab_pkg::CmdJump) begin
            cmd_d   = rx_byte_i;
            phase_d = smab_pkg::PH_ADDR;
          end else if (rx_byte_i == smab_pkg::CmdReadInc || rx_byte_i == smab_pkg::CmdWrite ||
                       rx_byte_i == smab_pkg::CmdReadFix) begin
            cmd_d   = rx_byte_i;
            phase_d = smab_pkg::PH_TYPE;
          end
        end
        smab_pkg::PH_TYPE: begin
          size_d  = smab_pkg::size_code(rx_byte_i);
          phase_d = smab_pkg::PH_COUNT;
        end
        smab_pkg::PH_COUNT: begin
          word_d = word_sh;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 3'd4) begin
            items_d = word_sh;
            word_d  = 32'd0;
            bcnt_d  = 3'd0;
            phase_d = smab_pkg::PH_ADDR;
          end
        end
        smab_pkg::PH_ADDR: begin
          word_d = word_sh;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= 3'd4) begin
            addr_d  = addr_new;
            word_d  = 32'd0;
            bcnt_d  = 3'd0;
            phase_d = smab_pkg::PH_IDLE;
            if (cmd_q == smab_pkg::CmdCall || cmd_q == smab_pkg::CmdJump) begin
              res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, smab_pkg::AnsStart, 32'd0,
                                             32'd0, smab_pkg::SIZE_BYTE, 1'b0);
              n = n + CntW'(1);
              res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_START, 8'd0, 32'(addr_new),
                                             32'd0, smab_pkg::SIZE_BYTE,
                                             cmd_q == smab_pkg::CmdCall);
              n = n + CntW'(1);
            end else if (cmd_q == smab_pkg::CmdLoad) begin
              if (items_q == 32'd0) begin
                res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, smab_pkg::AnsLoad, 32'd0,
                                               32'd0, smab_pkg::SIZE_BYTE, 1'b0);
                n = n + CntW'(1);
              end else begin
                phase_d = smab_pkg::PH_DATA;
              end
            end else if (cmd_q == smab_pkg::CmdWrite) begin
              if (items_q == 32'd0 || size_q == smab_pkg::SIZE_NONE) begin
                res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, smab_pkg::AnsWrite, 32'd0,
                                               32'd0, smab_pkg::SIZE_BYTE, 1'b0);
                n = n + CntW'(1);
              end else begin
                phase_d = smab_pkg::PH_DATA;
              end
            end else begin
              res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, smab_pkg::AnsRead, 32'd0,
                                             32'd0, smab_pkg::SIZE_BYTE, 1'b0);
              n = n + CntW'(1);
              if (items_q != 32'd0 && size_q != smab_pkg::SIZE_NONE) begin
                res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_READ, 8'd0, 32'(addr_new),
                                               32'd0, size_q, 1'b0);
                n = n + CntW'(1);
                phase_d = smab_pkg::PH_WAIT;
              end
            end
          end
        end
        smab_pkg::PH_DATA: begin
          word_d = word_sh;
          bcnt_d = bcnt_inc;
          if (bcnt_inc >= nb) begin
            res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_WRITE, 8'd0, 32'(addr_q),
                                           word_sh, dsize, 1'b0);
            n = n + CntW'(1);
            addr_d  = addr_next;
            items_d = items_q - 32'd1;
            word_d  = 32'd0;
            bcnt_d  = 3'd0;
            if (items_q == 32'd1) begin
              res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX,
                                             (cmd_q == smab_pkg::CmdLoad) ?
                                             smab_pkg::AnsLoad : smab_pkg::AnsWrite,
                                             32'd0, 32'd0, smab_pkg::SIZE_BYTE, 1'b0);
              n = n + CntW'(1);
              phase_d = smab_pkg::PH_IDLE;
            end
          end
        end
        default: begin
          // drop host bytes while read data is due
        end
      endcase
    end else if (phase_q == smab_pkg::PH_WAIT && size_q != smab_pkg::SIZE_NONE) begin
      // send read data most significant byte first
      if (size_q == smab_pkg::SIZE_LONG) begin
        res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, read_data_i[31:24], 32'd0, 32'd0,
                                       smab_pkg::SIZE_BYTE, 1'b0);
        n = n + CntW'(1);
        res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, read_data_i[23:16], 32'd0, 32'd0,
                                       smab_pkg::SIZE_BYTE, 1'b0);
        n = n + CntW'(1);
      end
      if (size_q == smab_pkg::SIZE_LONG || size_q == smab_pkg::SIZE_WORD) begin
        res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, read_data_i[15:8], 32'd0, 32'd0,
                                       smab_pkg::SIZE_BYTE, 1'b0);
        n = n + CntW'(1);
      end
      res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_TX, read_data_i[7:0], 32'd0, 32'd0,
                                     smab_pkg::SIZE_BYTE, 1'b0);
      n = n + CntW'(1);
      items_d = items_q - 32'd1;
      if (cmd_q == smab_pkg::CmdReadInc) begin
        addr_d = addr_next;
      end
      if (items_q != 32'd1) begin
        res_o[n] = smab_pkg::mk_result(smab_pkg::KIND_READ, 8'd0,
                                       32'((cmd_q == smab_pkg::CmdReadInc) ? addr_next : addr_q),
                                       32'd0, size_q, 1'b0);
        n = n + CntW'(1);
      end else begin
        phase_d = smab_pkg::PH_IDLE;
      end
    end

    for (int i = 0; i < smab_pkg::MaxResults; i++) begin
      res_o[i].last = (CntW'(i) == n - CntW'(1));
    end
    res_cnt_o = n;
  end

endmodule

@@ rtl/smab_result_queue.sv @@
`timescale 1ns / 1ps

module smab_result_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  smab_pkg::result_list_t        res_i,
  input  logic [smab_pkg::CntWidth-1:0] res_cnt_i,
  input  logic                          take_i,
  output logic                          space_o,
  output logic                          valid_o,
  output smab_pkg::result_t             head_o
);

  localparam int unsigned CntW = smab_pkg::CntWidth;

  smab_pkg::result_list_t ent_q, ent_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[0];
  // take a new list once the last pending word leaves
  assign space_o = (cnt_q == '0) || (cnt_q == CntW'(1) && take_i);

  always_comb begin
    ent_d = ent_q;
    cnt_d = cnt_q;
    if (load_i) begin
      ent_d = res_i;
      cnt_d = res_cnt_i;
    end else if (take_i) begin
      for (int i = 0; i < smab_pkg::MaxResults - 1; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ test/tb_serial_memory_access_bridge_unit.sv @@
`timescale 1ns / 1ps

module tb_serial_memory_access_bridge_unit;

  localparam int unsigned AddrWidth   = 32;
  localparam logic [31:0] AddrMask    = 32'hFFFF_FFFF >> (32 - AddrWidth);
  localparam int unsigned RandomWords = 260;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldAfter   = 60;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned PauseAt     = 30;

  localparam logic OpHostByte = 1'b0;
  localparam logic OpReadData = 1'b1;

  // Not a valid type byte
  localparam logic [7:0] TypeBogus = 8'h03;

  localparam logic [7:0] CommandSet [7] = '{smab_pkg::CmdPing, smab_pkg::CmdLoad,
                                            smab_pkg::CmdCall, smab_pkg::CmdJump,
                                            smab_pkg::CmdReadInc, smab_pkg::CmdReadFix,
                                            smab_pkg::CmdWrite};
  localparam logic [7:0] TypeSet [3] = '{smab_pkg::TypeByte, smab_pkg::TypeWord,
                                         smab_pkg::TypeLong};

  typedef struct packed {
    logic        op;
    logic [7:0]  rx;
    logic [31:0] rd;
    logic        typed;
    logic        answered;
    logic [7:0]  answer;
  } step_row_t;

  localparam int NumDirected = 46;
  localparam step_row_t DirectedRows [NumDirected] = '{
    '{OpHostByte, smab_pkg::CmdPing,    32'h0,         1'b1, 1'b1, smab_pkg::AnsPing},
    '{OpHostByte, 8'hFF,                32'h0,         1'b1, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b1, 1'b0, 8'h00},
    '{OpReadData, 8'h00,                32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00},
    // call to the top of the address space
    '{OpHostByte, smab_pkg::CmdCall,    32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    // jump to zero
    '{OpHostByte, smab_pkg::CmdJump,    32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    // load with zero count answers right after the address
    '{OpHostByte, smab_pkg::CmdLoad,    32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h12,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h34,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h56,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h78,                32'h0,         1'b1, 1'b1, smab_pkg::AnsLoad},
    // write with an unknown type and maximum count moves no data
    '{OpHostByte, smab_pkg::CmdWrite,   32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, TypeBogus,            32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h10,                32'h0,         1'b1, 1'b1, smab_pkg::AnsWrite},
    // two long reads that wrap the address
    '{OpHostByte, smab_pkg::CmdReadInc, 32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, smab_pkg::TypeLong,   32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h00,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'h02,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFF,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hFC,                32'h0,         1'b0, 1'b0, 8'h00},
    '{OpHostByte, 8'hA5,                32'h0,         1'b1, 1'b0, 8'h00},
    '{OpReadData, 8'h00,                32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00},
    '{OpReadData, 8'h00,                32'h0000_0000, 1'b0, 1'b0, 8'h00}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic [31:0] read_data_i = 32'h0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic [31:0] bus_address_o;
  logic [31:0] write_value_o;
  logic [1:0]  access_size_o;
  logic        call_mode_o;
  logic        last_o;

  serial_memory_access_bridge_unit #(
    .ADDRESS_WIDTH(AddrWidth)
  ) DUT (.*);

  always #4 clk_i = ~clk_i;

  // Parser state mirrored from the bridge
  smab_pkg::phase_e br_phase = smab_pkg::PH_IDLE;
  logic [7:0]       br_cmd   = 8'h00;
  logic [7:0]       br_type  = 8'h00;
  logic [31:0]      br_left  = 32'h0;
  logic [31:0]      br_addr  = 32'h0;
  logic [31:0]      br_word  = 32'h0;
  int unsigned      br_cnt   = 0;

  smab_pkg::result_t due_results [$];
  int                last_made;
  int unsigned       bridge_words    = 0;
  int unsigned       stray_words     = 0;
  int unsigned       results_checked = 0;
  int unsigned       mismatches      = 0;
  bit                sender_calm     = 1'b0;

  function automatic smab_pkg::size_e type_size(logic [7:0] t);
    if (t == smab_pkg::TypeByte) return smab_pkg::SIZE_BYTE;
    if (t == smab_pkg::TypeWord) return smab_pkg::SIZE_WORD;
    if (t == smab_pkg::TypeLong) return smab_pkg::SIZE_LONG;
    return smab_pkg::SIZE_NONE;
  endfunction

  function automatic int unsigned size_len(smab_pkg::size_e s);
    return 1 << int'(s);
  endfunction

  function automatic void due(smab_pkg::kind_e k, logic [7:0] tx, logic [31:0] a,
                              logic [31:0] v, smab_pkg::size_e s, logic c, logic fin);
    smab_pkg::result_t r;
    r.kind        = k;
    r.tx_byte     = tx;
    r.bus_address = a;
    r.write_value = v;
    r.size        = s;
    r.call_mode   = c;
    r.last        = fin;
    due_results.push_back(r);
  endfunction

  // Advance the mirrored parser by one word and queue what it emits
  function automatic int parse_bridge_word(logic op, logic [7:0] b, logic [31:0] d);
    smab_pkg::size_e   sz;
    smab_pkg::size_e   dsz;
    int unsigned       nb;
    int                n0;
    smab_pkg::result_t r;
    sz = type_size(br_type);
    n0 = due_results.size();
    if (op == OpHostByte) begin
      case (br_phase)
        smab_pkg::PH_IDLE: begin
          br_word = '0;
          br_cnt  = 0;
          if (b == smab_pkg::CmdPing) begin
            due(smab_pkg::KIND_TX, smab_pkg::AnsPing, '0, '0, smab_pkg::SIZE_BYTE, 1'b0, 1'b0);
          end else if (b == smab_pkg::CmdLoad) begin
            br_cmd   = b;
            br_phase = smab_pkg::PH_COUNT;
          end else if (b == smab_pkg::CmdCall || b == smab_pkg::CmdJump) begin
            br_cmd   = b;
            br_phase = smab_pkg::PH_ADDR;
          end else if (b == smab_pkg::CmdReadInc || b == smab_pkg::CmdWrite ||
                       b == smab_pkg::CmdReadFix) begin
            br_cmd   = b;
            br_phase = smab_pkg::PH_TYPE;
          end
        end
        smab_pkg::PH_TYPE: begin
          br_type  = b;
          br_phase = smab_pkg::PH_COUNT;
        end
        smab_pkg::PH_COUNT: begin
          br_word = {br_word[23:0], b};
          br_cnt++;
          if (br_cnt >= 4) begin
            br_left  = br_word;
            br_word  = '0;
            br_cnt   = 0;
            br_phase = smab_pkg::PH_ADDR;
          end
        end
        smab_pkg::PH_ADDR: begin
          br_word = {br_word[23:0], b};
          br_cnt++;
          if (br_cnt >= 4) begin
            br_addr  = br_word & AddrMask;
            br_word  = '0;
            br_cnt   = 0;
            br_phase = smab_pkg::PH_IDLE;
            if (br_cmd == smab_pkg::CmdCall || br_cmd == smab_pkg::CmdJump) begin
              due(smab_pkg::KIND_TX, smab_pkg::AnsStart, '0, '0, smab_pkg::SIZE_BYTE,
                  1'b0, 1'b0);
              due(smab_pkg::KIND_START, 8'h00, br_addr, '0, smab_pkg::SIZE_BYTE,
                  br_cmd == smab_pkg::CmdCall, 1'b0);
            end else if (br_cmd == smab_pkg::CmdLoad) begin
              if (br_left == 0) begin
                due(smab_pkg::KIND_TX, smab_pkg::AnsLoad, '0, '0, smab_pkg::SIZE_BYTE,
                    1'b0, 1'b0);
              end else begin
                br_phase = smab_pkg::PH_DATA;
              end
            end else if (br_cmd == smab_pkg::CmdWrite) begin
              if (br_left == 0 || sz == smab_pkg::SIZE_NONE) begin
                due(smab_pkg::KIND_TX, smab_pkg::AnsWrite, '0, '0, smab_pkg::SIZE_BYTE,
                    1'b0, 1'b0);
              end else begin
                br_phase = smab_pkg::PH_DATA;
              end
            end else begin
              due(smab_pkg::KIND_TX, smab_pkg::AnsRead, '0, '0, smab_pkg::SIZE_BYTE,
                  1'b0, 1'b0);
              if (br_left != 0 && sz != smab_pkg::SIZE_NONE) begin
                due(smab_pkg::KIND_READ, 8'h00, br_addr, '0, sz, 1'b0, 1'b0);
                br_phase = smab_pkg::PH_WAIT;
              end
            end
          end
        end
        smab_pkg::PH_DATA: begin
          // load always moves bytes, whatever type was seen last
          dsz     = (br_cmd == smab_pkg::CmdLoad) ? smab_pkg::SIZE_BYTE : sz;
          nb      = size_len(dsz);
          br_word = {br_word[23:0], b};
          br_cnt++;
          if (br_cnt >= nb) begin
            due(smab_pkg::KIND_WRITE, 8'h00, br_addr, br_word, dsz, 1'b0, 1'b0);
            br_addr = (br_addr + nb) & AddrMask;
            br_left--;
            br_word = '0;
            br_cnt  = 0;
            if (br_left == 0) begin
              due(smab_pkg::KIND_TX,
                  (br_cmd == smab_pkg::CmdLoad) ? smab_pkg::AnsLoad : smab_pkg::AnsWrite,
                  '0, '0, smab_pkg::SIZE_BYTE, 1'b0, 1'b0);
              br_phase = smab_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end else if (br_phase == smab_pkg::PH_WAIT && sz != smab_pkg::SIZE_NONE) begin
      nb = size_len(sz);
      for (int i = nb; i > 0; i--) begin
        due(smab_pkg::KIND_TX, d[8*(i-1) +: 8], '0, '0, smab_pkg::SIZE_BYTE, 1'b0, 1'b0);
      end
      br_left--;
      if (br_cmd == smab_pkg::CmdReadInc) br_addr = (br_addr + nb) & AddrMask;
      if (br_left != 0) due(smab_pkg::KIND_READ, 8'h00, br_addr, '0, sz, 1'b0, 1'b0);
      else br_phase = smab_pkg::PH_IDLE;
    end
    if (due_results.size() > n0) begin
      r      = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
    return due_results.size() - n0;
  endfunction

  function automatic int unsigned sender_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Offer one word, hold it while stalled, then predict its results
  task automatic offer_word(logic op, logic [7:0] b, logic [31:0] d, bit live);
    int unsigned idle;
    idle = sender_idle();
    repeat (idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    rx_byte_i   <= (op == OpReadData) ? 8'($urandom) : b;
    read_data_i <= (op == OpReadData) ? d : $urandom;
    do @(posedge clk_i); while (in_stall_o);
    last_made = parse_bridge_word(op, b, d);
    if (live) bridge_words++;
    else stray_words++;
  endtask

  function automatic logic [31:0] read_pattern();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'hFFFF_FFFF;
    if (r == 1) return 32'h0;
    return $urandom;
  endfunction

  // One well-formed command with random content, now and then with noise before it or among its data
  task automatic send_command();
    logic [7:0]      cmd;
    logic [7:0]      typ;
    logic [7:0]      junk;
    logic [31:0]     count;
    logic [31:0]     addr;
    smab_pkg::size_e sz;
    int unsigned     nb;
    if ($urandom_range(0, 11) == 0) begin
      junk = 8'($urandom);
      // keep noise off the command codes so the parser stays idle
      if (junk[7:4] == 4'h0) junk[7] = 1'b1;
      if ($urandom_range(0, 1) != 0) offer_word(OpHostByte, junk, '0, 1'b0);
      else offer_word(OpReadData, 8'h00, $urandom, 1'b0);
    end
    cmd = CommandSet[$urandom_range(0, 6)];
    typ = ($urandom_range(0, 6) == 0) ? 8'($urandom) : TypeSet[$urandom_range(0, 2)];
    sz  = type_size(typ);
    if (sz == smab_pkg::SIZE_NONE && cmd != smab_pkg::CmdLoad && $urandom_range(0, 1) != 0)
      count = $urandom;
    else count = $urandom_range(0, 4);
    if ($urandom_range(0, 4) == 0) addr = 32'hFFFF_FFFF - $urandom_range(0, 7);
    else addr = $urandom;

    offer_word(OpHostByte, cmd, '0, 1'b1);
    if (cmd == smab_pkg::CmdPing) return;
    if (cmd == smab_pkg::CmdReadInc || cmd == smab_pkg::CmdReadFix ||
        cmd == smab_pkg::CmdWrite) begin
      offer_word(OpHostByte, typ, '0, 1'b1);
    end
    if (cmd != smab_pkg::CmdCall && cmd != smab_pkg::CmdJump) begin
      for (int k = 3; k >= 0; k--) offer_word(OpHostByte, count[8*k +: 8], '0, 1'b1);
    end
    for (int k = 3; k >= 0; k--) offer_word(OpHostByte, addr[8*k +: 8], '0, 1'b1);

    if (cmd == smab_pkg::CmdLoad ||
        (cmd == smab_pkg::CmdWrite && sz != smab_pkg::SIZE_NONE)) begin
      nb = (cmd == smab_pkg::CmdLoad) ? 1 : size_len(sz);
      repeat (count * nb) begin
        if ($urandom_range(0, 19) == 0) offer_word(OpReadData, 8'h00, $urandom, 1'b0);
        offer_word(OpHostByte, 8'($urandom), '0, 1'b1);
      end
    end else if ((cmd == smab_pkg::CmdReadInc || cmd == smab_pkg::CmdReadFix) &&
                 sz != smab_pkg::SIZE_NONE) begin
      repeat (count) begin
        if ($urandom_range(0, 9) == 0) offer_word(OpHostByte, 8'($urandom), '0, 1'b0);
        offer_word(OpReadData, 8'h00, read_pattern(), 1'b1);
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Output side: check each accepted word, then pick the next stall
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk_i) begin
    smab_pkg::result_t want;
    int unsigned       r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (due_results.size() == 0) begin
          $error("result word with none expected: kind_o %0d, tx_byte_o 0x%0h",
                 kind_o, tx_byte_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("bus_address", want.bus_address, bus_address_o);
          check_field("write_value", want.write_value, write_value_o);
          check_field("access_size", want.size, access_size_o);
          check_field("call_mode", want.call_mode, call_mode_o);
          check_field("last", want.last, last_o);
        end
      end
      if (!hold_done && results_checked >= HoldAfter) begin
        hold_left = LongHold;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (calm_left != 0) begin
        calm_left--;
        out_stall_i <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          calm_left = $urandom_range(40, 120);
          out_stall_i <= 1'b0;
        end else if (r < 28) begin
          stall_left = $urandom_range(0, 2);
          out_stall_i <= 1'b1;
        end else if (r < 31) begin
          stall_left = $urandom_range(5, 30);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin
    step_row_t row;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      offer_word(row.op, row.rx, row.rd, 1'b1);
      if (row.typed) begin
        // replace the prediction with the hand-written answer
        repeat (last_made) void'(due_results.pop_back());
        if (row.answered) begin
          due(smab_pkg::KIND_TX, row.answer, '0, '0, smab_pkg::SIZE_BYTE, 1'b0, 1'b1);
        end
      end
    end

    bridge_words = 0;
    for (int seq = 0; bridge_words < RandomWords; seq++) begin
      sender_calm = ($urandom_range(0, 5) == 0);
      if (seq == PauseAt) begin
        in_valid_i <= 1'b0;
        while (due_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      send_command();
    end

    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d random parser words plus %0d ignored strays after the directed table.",
             bridge_words, stray_words);
    $display("Checked %0d result words across a long output hold and a full mid-run drain.",
             results_checked);
    if (mismatches == 0) begin
      $display("tb_serial_memory_access_bridge_unit OK");
    end else begin
      $display("tb_serial_memory_access_bridge_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_serial_memory_access_bridge_unit NOT OK");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/smab_pkg.sv
rtl/smab_parser.sv
rtl/smab_result_queue.sv
rtl/serial_memory_access_bridge_unit.sv
test/tb_serial_memory_access_bridge_unit.sv
